### design/dhs_pkg.sv
// shared types and constants for the differential drive heading steer
// holds the cordic arctangent table, angle constants and register indexes
// no dependencies
package dhs_pkg;

  localparam int ZW           = 35;
  localparam int XYW          = 32;
  localparam int XY_SHIFT     = 20;
  localparam int ATAN_ENTRIES = 20;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 14;

  localparam logic signed [ZW-1:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 35'sd1686629713;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_SPEED       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEER_GAIN       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ARRIVE_TOLERANCE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_THRESHOLD   = 2'd3;

  typedef struct packed {
    logic               en;
    logic               arrived;
    logic signed [14:0] heading;
  } side_t;

  function automatic logic signed [ZW-1:0] atan_q30(input int unsigned idx);
    logic signed [ZW-1:0] r;
    unique case (idx)
      0:       r = 35'sd843314857;
      1:       r = 35'sd497837829;
      2:       r = 35'sd263043837;
      3:       r = 35'sd133525159;
      4:       r = 35'sd67021687;
      5:       r = 35'sd33543516;
      6:       r = 35'sd16775851;
      7:       r = 35'sd8388437;
      8:       r = 35'sd4194283;
      9:       r = 35'sd2097149;
      10:      r = 35'sd1048576;
      11:      r = 35'sd524288;
      12:      r = 35'sd262144;
      13:      r = 35'sd131072;
      14:      r = 35'sd65536;
      15:      r = 35'sd32768;
      16:      r = 35'sd16384;
      17:      r = 35'sd8192;
      18:      r = 35'sd4096;
      19:      r = 35'sd2048;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### design/differential_drive_heading_steer.sv
// Differential drive heading steer: wheel speed commands from position,
// target and heading, through a pipelined cordic bearing and error stages.
// Depends on dhs_pkg and dhs_cordic.
//
// Use: an input transfer happens when in_valid_i is high and in_stall_o is
// low; a result transfer when out_valid_o is high and out_stall_i is low.
// Every input transfer yields exactly one result, in order.
// Pipeline: min(CORDIC_STAGES, 20) + 6 register stages.
// Throughput: one item per cycle while the receiver does not stall, set by
// the one-iteration-per-stage cordic and the single multiplier stage.
// A stalled receiver holds the output register; earlier stages keep filling
// until every stage holds an item, then in_stall_o rises. Nothing is lost.
// Reset empties the pipeline and loads the register defaults: base speed
// 820, steer gain 10, arrival tolerance 3, turn threshold 6434.
// Registers are written through cfg_we_i, cfg_index_i and cfg_data_i; the user
// must write them only while no item is in flight, the block does not enforce it.
module differential_drive_heading_steer #(
  parameter int ANGLE_FRAC_BITS = 12,
  parameter int CORDIC_STAGES   = 14
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [dhs_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [dhs_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               move_enable_i,
  input  logic [7:0]                         current_x_i,
  input  logic [7:0]                         current_y_i,
  input  logic [7:0]                         target_x_i,
  input  logic [7:0]                         target_y_i,
  input  logic signed [14:0]                 heading_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               speed_update_o,
  output logic                               arrived_o,
  output logic                               spin_mode_o,
  output logic signed [13:0]                 left_speed_o,
  output logic signed [13:0]                 right_speed_o
);

  localparam int F  = ANGLE_FRAC_BITS;
  localparam int ZW = dhs_pkg::ZW;
  localparam int AW = F + 5;
  localparam int SW = F + 14;
  localparam logic signed [ZW-1:0] ROUND_BIAS = ZW'(64'sd1 <<< (29 - F));
  localparam int PI_I = int'((64'(dhs_pkg::PI_Q30) + (64'sd1 <<< (29 - F))) >>> (30 - F));
  localparam logic signed [AW-1:0] PI_Q     = AW'(PI_I);
  localparam logic signed [AW-1:0] TWO_PI_Q = AW'(2 * PI_I);
  localparam logic signed [SW-1:0] TRUNC_BIAS = SW'((64'sd1 <<< F) - 1);

  // configuration registers
  logic [11:0] base_speed_q;
  logic [7:0]  steer_gain_q;
  logic [3:0]  arrive_tol_q;
  logic [13:0] turn_thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_speed_q <= 12'd820;
      steer_gain_q <= 8'd10;
      arrive_tol_q <= 4'd3;
      turn_thr_q   <= 14'd6434;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        dhs_pkg::CFG_BASE_SPEED:       base_speed_q <= cfg_data_i[11:0];
        dhs_pkg::CFG_STEER_GAIN:       steer_gain_q <= cfg_data_i[7:0];
        dhs_pkg::CFG_ARRIVE_TOLERANCE: arrive_tol_q <= cfg_data_i[3:0];
        dhs_pkg::CFG_TURN_THRESHOLD:   turn_thr_q   <= cfg_data_i[13:0];
        default: ;
      endcase
    end
  end

  // axis errors and arrival check ahead of the cordic
  logic signed [8:0] dx;
  logic signed [8:0] dy;
  logic [8:0]        adx;
  logic [8:0]        ady;
  dhs_pkg::side_t    side_in;

  assign dx  = $signed({1'b0, target_x_i}) - $signed({1'b0, current_x_i});
  assign dy  = $signed({1'b0, target_y_i}) - $signed({1'b0, current_y_i});
  assign adx = dx[8] ? 9'(-dx) : 9'(dx);
  assign ady = dy[8] ? 9'(-dy) : 9'(dy);
  assign side_in.en      = move_enable_i;
  assign side_in.arrived = (adx < 9'(arrive_tol_q)) && (ady < 9'(arrive_tol_q));
  assign side_in.heading = heading_i;

  logic                 c_ready;
  logic                 c_valid;
  logic signed [ZW-1:0] c_z;
  dhs_pkg::side_t       c_side;

  logic rdy1, rdy2, rdy3, rdy4, rdy_out;
  logic v1_q, v2_q, v3_q, v4_q, out_valid_q;

  dhs_cordic #(
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_cordic (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (c_ready),
    .dx_i       (dx),
    .dy_i       (dy),
    .side_i     (side_in),
    .out_valid_o(c_valid),
    .out_ready_i(rdy1),
    .z_o        (c_z),
    .side_o     (c_side)
  );

  assign in_stall_o = !c_ready;

  assign rdy_out = !out_valid_q || !out_stall_i;
  assign rdy4    = !v4_q || rdy_out;
  assign rdy3    = !v3_q || rdy4;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (rdy1)    v1_q        <= c_valid;
      if (rdy2)    v2_q        <= v1_q;
      if (rdy3)    v3_q        <= v2_q;
      if (rdy4)    v4_q        <= v3_q;
      if (rdy_out) out_valid_q <= v4_q;
    end
  end

  // stage 1: round bearing, saturate heading
  logic signed [ZW-1:0] z_rnd;
  int                   head_i;
  int                   head_sat;
  logic signed [AW-1:0] brg_q, head_q;
  dhs_pkg::side_t       side1_q;

  assign z_rnd  = c_z + ROUND_BIAS;
  assign head_i = int'(c_side.heading);
  assign head_sat = (head_i > PI_I) ? PI_I : ((head_i < -PI_I) ? -PI_I : head_i);

  // stage 2: shortest wrapped error and turn direction
  logic signed [AW-1:0] d_abs, d_alt;
  logic                 brg_gt;
  logic signed [AW-1:0] diff_q;
  logic                 neg2_q;
  dhs_pkg::side_t       side2_q;

  assign brg_gt = brg_q > head_q;
  assign d_abs  = brg_gt ? brg_q - head_q : head_q - brg_q;
  assign d_alt  = TWO_PI_Q - d_abs;

  // stage 3: gain times error, spin decision
  logic signed [SW-1:0] prod_q;
  logic                 neg3_q, spin3_q;
  dhs_pkg::side_t       side3_q;

  // stage 4: wheel speeds in angle format, base plus or minus turn, or turn alone in spin
  logic signed [SW-1:0] turn;
  logic signed [SW-1:0] base_f;
  logic signed [SW-1:0] left_q, right_q;
  logic                 spin4_q;
  dhs_pkg::side_t       side4_q;

  assign turn   = neg3_q ? -prod_q : prod_q;
  assign base_f = $signed({2'b00, base_speed_q, F'(0)});

  // output: truncate toward zero and gate
  logic signed [SW-1:0] left_t, right_t;
  logic                 upd;

  assign left_t  = left_q[SW-1]  ? (left_q + TRUNC_BIAS) >>> F  : left_q >>> F;
  assign right_t = right_q[SW-1] ? (right_q + TRUNC_BIAS) >>> F : right_q >>> F;
  assign upd     = side4_q.en && !side4_q.arrived;

  logic               upd_q, arr_q, spin_q;
  logic signed [13:0] left_o_q, right_o_q;

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      brg_q   <= AW'(z_rnd >>> (30 - F));
      head_q  <= AW'(head_sat);
      side1_q <= c_side;
    end
    if (rdy2) begin
      if (d_abs > d_alt) begin
        diff_q <= d_alt;
        neg2_q <= !brg_gt;
      end else begin
        diff_q <= d_abs;
        neg2_q <= brg_gt;
      end
      side2_q <= side1_q;
    end
    if (rdy3) begin
      prod_q  <= SW'($signed({1'b0, steer_gain_q})) * SW'(diff_q);
      neg3_q  <= neg2_q;
      spin3_q <= !(32'(diff_q) < 32'($signed({1'b0, turn_thr_q})));
      side3_q <= side2_q;
    end
    if (rdy4) begin
      left_q  <= spin3_q ? turn  : base_f + turn;
      right_q <= spin3_q ? -turn : base_f - turn;
      spin4_q <= spin3_q;
      side4_q <= side3_q;
    end
    if (rdy_out) begin
      upd_q     <= upd;
      arr_q     <= side4_q.en && side4_q.arrived;
      spin_q    <= upd && spin4_q;
      left_o_q  <= upd ? left_t[13:0]  : 14'sd0;
      right_o_q <= upd ? right_t[13:0] : 14'sd0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign speed_update_o = upd_q;
  assign arrived_o      = arr_q;
  assign spin_mode_o    = spin_q;
  assign left_speed_o   = left_o_q;
  assign right_speed_o  = right_o_q;

endmodule

### design/dhs_cordic.sv
// pipelined vectoring cordic giving the bearing of (dx, dy) in q30 radians
// a pre-rotation register, then one iteration per register stage, with valid bits and a stall chain
// depends on dhs_pkg
module dhs_cordic #(
  parameter int CORDIC_STAGES = 14
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [8:0]                 dx_i,
  input  logic signed [8:0]                 dy_i,
  input  dhs_pkg::side_t                    side_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [dhs_pkg::ZW-1:0]     z_o,
  output dhs_pkg::side_t                    side_o
);

  localparam int NS = (CORDIC_STAGES > dhs_pkg::ATAN_ENTRIES) ?
                      dhs_pkg::ATAN_ENTRIES : CORDIC_STAGES;
  localparam int XYW = dhs_pkg::XYW;
  localparam int ZW  = dhs_pkg::ZW;

  logic [NS:0]              vld_q;
  logic [NS:0]              rdy;
  logic [NS:0]              byp_q;
  logic signed [XYW-1:0]    x_q [NS+1];
  logic signed [XYW-1:0]    y_q [NS+1];
  logic signed [ZW-1:0]     z_q [NS+1];
  dhs_pkg::side_t           side_q [NS+1];
  logic signed [XYW-1:0]    x_d [NS+1];
  logic signed [XYW-1:0]    y_d [NS+1];
  logic signed [ZW-1:0]     z_d [NS+1];

  // pre-rotation into the right half plane, vertical vectors bypass
  logic                     neg;
  logic                     byp;
  logic signed [8:0]        dxa;
  logic signed [8:0]        dyn;

  assign byp = (dx_i == 9'sd0);
  assign neg = dx_i[8];
  assign dxa = neg ? -dx_i : dx_i;
  assign dyn = neg ? -dy_i : dy_i;
  assign x_d[0] = XYW'(dxa) <<< dhs_pkg::XY_SHIFT;
  assign y_d[0] = XYW'(dyn) <<< dhs_pkg::XY_SHIFT;
  assign z_d[0] = byp ? ((dy_i > 9'sd0) ? dhs_pkg::HALF_PI_Q30 : -dhs_pkg::HALF_PI_Q30) :
                  neg ? ((dy_i >= 9'sd0) ? dhs_pkg::PI_Q30 : -dhs_pkg::PI_Q30) : '0;

  for (genvar k = 0; k < NS; k++) begin : g_iter
    localparam logic signed [ZW-1:0] ATAN = dhs_pkg::atan_q30(k);
    logic signed [XYW-1:0] xs;
    logic signed [XYW-1:0] ys;
    assign xs = x_q[k] >>> k;
    assign ys = y_q[k] >>> k;
    assign x_d[k+1] = byp_q[k] ? x_q[k] : (y_q[k][XYW-1] ? x_q[k] - ys : x_q[k] + ys);
    assign y_d[k+1] = byp_q[k] ? y_q[k] : (y_q[k][XYW-1] ? y_q[k] + xs : y_q[k] - xs);
    assign z_d[k+1] = byp_q[k] ? z_q[k] : (y_q[k][XYW-1] ? z_q[k] - ATAN : z_q[k] + ATAN);
    assign rdy[k] = !vld_q[k] || rdy[k+1];
  end

  assign rdy[NS]     = !vld_q[NS] || out_ready_i;
  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[NS];
  assign z_o         = z_q[NS];
  assign side_o      = side_q[NS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k <= NS; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      x_q[0]    <= x_d[0];
      y_q[0]    <= y_d[0];
      z_q[0]    <= z_d[0];
      byp_q[0]  <= byp;
      side_q[0] <= side_i;
    end
    for (int k = 1; k <= NS; k++) begin
      if (rdy[k]) begin
        x_q[k]    <= x_d[k];
        y_q[k]    <= y_d[k];
        z_q[k]    <= z_d[k];
        byp_q[k]  <= byp_q[k-1];
        side_q[k] <= side_q[k-1];
      end
    end
  end

endmodule
